### rtl/core/spd_pkg.sv
// Package for the swing pivot detector: the item types of both channels,
// the register map and the control groups that pass between its modules.
// It depends on nothing else.
`timescale 1ns / 1ps

package spd_pkg;

    localparam int MAX_ARM     = 16;
    localparam int PRICE_WIDTH = 32;
    localparam int FIELD_WIDTH = 32;
    localparam int COUNT_WIDTH = 32;
    localparam int ARM_WIDTH   = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_BARS   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_BARS  = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_START_INDEX = CFG_INDEX_W'(2);

    localparam logic [ARM_WIDTH-1:0]   LEFT_BARS_RESET   = ARM_WIDTH'(2);
    localparam logic [ARM_WIDTH-1:0]   RIGHT_BARS_RESET  = ARM_WIDTH'(2);
    localparam logic [COUNT_WIDTH-1:0] START_INDEX_RESET = '0;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX         = '1;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] bar_high;
        logic signed [FIELD_WIDTH-1:0] bar_low;
        logic                          last_bar;
    } bar_t;

    typedef struct packed {
        logic                   swing_high;
        logic                   swing_low;
        logic [COUNT_WIDTH-1:0] bar_index;
        logic [COUNT_WIDTH-1:0] report_count;
    } pivot_t;

    typedef struct packed {
        logic shift;
        logic check;
    } cell_ctl_t;

    typedef struct packed {
        logic high_blocks;
        logic low_blocks;
    } cell_flags_t;

endpackage

### rtl/core/spd_cell.sv
// One window cell of the swing pivot detector: holds one bar's high and low,
// passes them on to its neighbour and tests them against the candidate.
// It depends on spd_pkg.
`timescale 1ns / 1ps

module spd_cell #(
    parameter int PriceWidth = spd_pkg::PRICE_WIDTH
) (
    input  logic                    clk,
    input  spd_pkg::cell_ctl_t      ctl,
    input  logic [PriceWidth-1:0]   prev_high,
    input  logic [PriceWidth-1:0]   prev_low,
    input  logic [PriceWidth-1:0]   cand_high,
    input  logic [PriceWidth-1:0]   cand_low,
    output logic [PriceWidth-1:0]   cur_high,
    output logic [PriceWidth-1:0]   cur_low,
    output spd_pkg::cell_flags_t    flags
);

    logic [PriceWidth-1:0] high_reg;
    logic [PriceWidth-1:0] low_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            high_reg <= prev_high;
            low_reg  <= prev_low;
        end
    end

    assign cur_high = high_reg;
    assign cur_low  = low_reg;

    always_comb
    begin
        flags.high_blocks = ctl.check && ($signed(high_reg) >= $signed(cand_high));
        flags.low_blocks  = ctl.check && ($signed(low_reg) <= $signed(cand_low));
    end

endmodule

### rtl/core/spd_window.sv
// Bar window of the swing pivot detector: a chain of cells, the candidate
// register and the combination of the cells' verdicts.
// It depends on spd_pkg and spd_cell.
`timescale 1ns / 1ps

module spd_window #(
    parameter  int MaxArm     = spd_pkg::MAX_ARM,
    parameter  int PriceWidth = spd_pkg::PRICE_WIDTH,
    localparam int Depth      = 2 * MaxArm + 1,
    localparam int IdxW       = $clog2(Depth)
) (
    input  logic                  clk,
    input  logic                  shift,
    input  logic                  load_cand,
    input  logic [PriceWidth-1:0] new_high,
    input  logic [PriceWidth-1:0] new_low,
    input  logic [IdxW-1:0]       cand_idx,
    input  logic [IdxW-1:0]       span,
    output logic                  high_hit,
    output logic                  low_hit
);

    logic [PriceWidth-1:0] high_tap [Depth];
    logic [PriceWidth-1:0] low_tap  [Depth];
    spd_pkg::cell_flags_t  flags    [Depth];
    logic [PriceWidth-1:0] cand_high_reg;
    logic [PriceWidth-1:0] cand_low_reg;

    for (genvar k = 0; k < Depth; k++)
    begin : g_cell
        spd_pkg::cell_ctl_t    ctl;
        logic [PriceWidth-1:0] prev_high;
        logic [PriceWidth-1:0] prev_low;

        if (k == 0)
        begin : g_head
            assign prev_high = new_high;
            assign prev_low  = new_low;
        end
        else
        begin : g_body
            assign prev_high = high_tap[k-1];
            assign prev_low  = low_tap[k-1];
        end

        assign ctl.shift = shift;
        assign ctl.check = (IdxW'(k) <= span) && (IdxW'(k) != cand_idx);

        spd_cell #(
            .PriceWidth (PriceWidth)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .prev_high (prev_high),
            .prev_low  (prev_low),
            .cand_high (cand_high_reg),
            .cand_low  (cand_low_reg),
            .cur_high  (high_tap[k]),
            .cur_low   (low_tap[k]),
            .flags     (flags[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (load_cand)
        begin
            cand_high_reg <= high_tap[cand_idx];
            cand_low_reg  <= low_tap[cand_idx];
        end
    end

    always_comb
    begin
        high_hit = 1'b0;
        low_hit  = 1'b0;
        for (int k = 0; k < Depth; k++)
        begin
            high_hit = high_hit | flags[k].high_blocks;
            low_hit  = low_hit | flags[k].low_blocks;
        end
    end

endmodule

### rtl/core/swing_pivot_detector.sv
// Top level of the swing pivot detector: handshakes, configuration
// registers, series counters and sequencing. It depends on spd_pkg and spd_window.
// The block takes one bar at a time and keeps the newest 2*MaxArm+1 bars in a
// chain of cells; a bar that yields no report leaves it ready for the next bar,
// and one that yields a report goes through shift, candidate select and compare
// before its item appears at the output. The next bar is taken only once the
// report has gone out, so a stalled output holds back the input.
// Arms above MaxArm count as MaxArm, and a bar with last_bar set ends the series.
`timescale 1ns / 1ps

module swing_pivot_detector #(
    parameter int MaxArm     = spd_pkg::MAX_ARM,
    parameter int PriceWidth = spd_pkg::PRICE_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [spd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [spd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             bar_valid,
    output logic                             bar_ready,
    input  spd_pkg::bar_t                    bar,
    output logic                             pivot_valid,
    input  logic                             pivot_ready,
    output spd_pkg::pivot_t                  pivot
);

    localparam int Depth = 2 * MaxArm + 1;
    localparam int IdxW  = $clog2(Depth);
    localparam int AW    = spd_pkg::ARM_WIDTH;
    localparam int CW    = spd_pkg::COUNT_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEL,
        ST_CMP,
        ST_OUT
    } state_t;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            left_bars_reg, left_bars_next;
    logic [AW-1:0]            right_bars_reg, right_bars_next;
    logic [CW-1:0]            start_index_reg, start_index_next;
    logic [CW-1:0]            bars_seen_reg, bars_seen_next;
    logic [CW-1:0]            reports_made_reg, reports_made_next;
    logic [CW-1:0]            rep_index_reg, rep_index_next;
    logic [CW-1:0]            rep_count_reg, rep_count_next;
    logic [IdxW-1:0]          cand_idx_reg, cand_idx_next;
    logic [IdxW-1:0]          span_reg, span_next;
    logic                     pivot_valid_reg, pivot_valid_next;
    spd_pkg::pivot_t          pivot_reg, pivot_next;

    logic [IdxW-1:0]          left_arm;
    logic [IdxW-1:0]          right_arm;
    logic [IdxW-1:0]          span_now;
    logic                     report_now;
    logic [CW-1:0]            count_now;
    logic                     bar_fire;
    logic                     cfg_fire;
    logic                     high_hit;
    logic                     low_hit;
    logic [PriceWidth-1:0]    new_high;
    logic [PriceWidth-1:0]    new_low;

    function automatic logic [IdxW-1:0] clamp_arm(input logic [AW-1:0] value);
        logic [IdxW-1:0] result;
        if (32'(value) > 32'(MaxArm))
        begin
            result = IdxW'(MaxArm);
        end
        else
        begin
            result = IdxW'(value);
        end
        return result;
    endfunction

    assign cfg_ready   = 1'b1;
    assign bar_ready   = (state_reg == ST_IDLE);
    assign pivot_valid = pivot_valid_reg;
    assign pivot       = pivot_reg;
    assign bar_fire    = bar_valid && bar_ready;
    assign cfg_fire    = cfg_valid && cfg_ready;

    // Prices wider than the field are taken as the field's unsigned value.
    assign new_high = PriceWidth'($unsigned(bar.bar_high));
    assign new_low  = PriceWidth'($unsigned(bar.bar_low));

    always_comb
    begin
        left_arm   = clamp_arm(left_bars_reg);
        right_arm  = clamp_arm(right_bars_reg);
        span_now   = left_arm + right_arm;
        report_now = (bars_seen_reg >= CW'(span_now)) && (bars_seen_reg >= start_index_reg);
        if (report_now && (reports_made_reg != spd_pkg::COUNT_MAX))
        begin
            count_now = reports_made_reg + CW'(1);
        end
        else
        begin
            count_now = reports_made_reg;
        end
    end

    spd_window #(
        .MaxArm     (MaxArm),
        .PriceWidth (PriceWidth)
    ) u_window (
        .clk       (clk),
        .shift     (bar_fire),
        .load_cand (state_reg == ST_SEL),
        .new_high  (new_high),
        .new_low   (new_low),
        .cand_idx  (cand_idx_reg),
        .span      (span_reg),
        .high_hit  (high_hit),
        .low_hit   (low_hit)
    );

    always_comb
    begin
        state_next        = state_reg;
        left_bars_next    = left_bars_reg;
        right_bars_next   = right_bars_reg;
        start_index_next  = start_index_reg;
        bars_seen_next    = bars_seen_reg;
        reports_made_next = reports_made_reg;
        rep_index_next    = rep_index_reg;
        rep_count_next    = rep_count_reg;
        cand_idx_next     = cand_idx_reg;
        span_next         = span_reg;
        pivot_valid_next  = pivot_valid_reg;
        pivot_next        = pivot_reg;

        if (cfg_fire)
        begin
            case (cfg_index)
                spd_pkg::REG_LEFT_BARS:   left_bars_next   = cfg_data[AW-1:0];
                spd_pkg::REG_RIGHT_BARS:  right_bars_next  = cfg_data[AW-1:0];
                spd_pkg::REG_START_INDEX: start_index_next = cfg_data[CW-1:0];
                default:                  ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (bar_fire)
                begin
                    cand_idx_next  = right_arm;
                    span_next      = span_now;
                    rep_index_next = bars_seen_reg;
                    rep_count_next = count_now;
                    if (bar.last_bar)
                    begin
                        bars_seen_next    = '0;
                        reports_made_next = '0;
                    end
                    else
                    begin
                        reports_made_next = count_now;
                        if (bars_seen_reg != spd_pkg::COUNT_MAX)
                        begin
                            bars_seen_next = bars_seen_reg + CW'(1);
                        end
                    end
                    if (report_now)
                    begin
                        state_next = ST_SEL;
                    end
                end
            end
            ST_SEL:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                pivot_next.swing_high   = !high_hit;
                pivot_next.swing_low    = !low_hit;
                pivot_next.bar_index    = rep_index_reg;
                pivot_next.report_count = rep_count_reg;
                pivot_valid_next        = 1'b1;
                state_next              = ST_OUT;
            end
            ST_OUT:
            begin
                if (pivot_ready)
                begin
                    pivot_valid_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            left_bars_reg    <= spd_pkg::LEFT_BARS_RESET;
            right_bars_reg   <= spd_pkg::RIGHT_BARS_RESET;
            start_index_reg  <= spd_pkg::START_INDEX_RESET;
            bars_seen_reg    <= '0;
            reports_made_reg <= '0;
            pivot_valid_reg  <= 1'b0;
            pivot_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            left_bars_reg    <= left_bars_next;
            right_bars_reg   <= right_bars_next;
            start_index_reg  <= start_index_next;
            bars_seen_reg    <= bars_seen_next;
            reports_made_reg <= reports_made_next;
            pivot_valid_reg  <= pivot_valid_next;
            pivot_reg        <= pivot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rep_index_reg <= rep_index_next;
        rep_count_reg <= rep_count_next;
        cand_idx_reg  <= cand_idx_next;
        span_reg      <= span_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (bar_fire && report_now) |=> !bar_ready)
        else $error("bar taken while the previous one was still in work");

    a_report_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (bar_fire && report_now) |=> ##2 pivot_valid)
        else $error("reporting bar did not produce an item");

    a_silent_bar: assert property (@(posedge clk) disable iff (!rst_n)
        (bar_fire && !report_now) |=> !pivot_valid)
        else $error("warm-up bar produced an item");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        pivot_valid |-> (pivot.report_count != '0))
        else $error("report item carries a zero report count");

endmodule

### sim/testbench.sv
// Self-checking testbench for swing_pivot_detector: directed bars from a table, then
// random series under three idling patterns, each report checked against the table
// or a predictor. Depends on spd_pkg and the swing_pivot_detector RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int WIN           = 2 * spd_pkg::MAX_ARM + 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 600;
    localparam int IW            = spd_pkg::CFG_INDEX_W;
    localparam int DW            = spd_pkg::CFG_DATA_W;
    localparam int AW            = spd_pkg::ARM_WIDTH;
    localparam int CW            = spd_pkg::COUNT_WIDTH;
    localparam int PW            = spd_pkg::PRICE_WIDTH;
    localparam logic [IW-1:0] REG_UNUSED = IW'(3);

    typedef enum logic [0:0] {ROW_BAR, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        spd_pkg::bar_t           item;
        bit                      typed;
        bit                      has_pivot;
        spd_pkg::pivot_t         want;
        logic [IW-1:0]           reg_idx;
        logic [DW-1:0]           reg_val;
    } row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [IW-1:0]           cfg_index = '0;
    logic [DW-1:0]           cfg_data = '0;
    logic                    bar_valid = 1'b0;
    logic                    bar_ready;
    spd_pkg::bar_t           bar = '0;
    logic                    pivot_valid;
    logic                    pivot_ready = 1'b0;
    spd_pkg::pivot_t         pivot;

    logic [AW-1:0]           left_arm;
    logic [AW-1:0]           right_arm;
    logic [CW-1:0]           first_index;
    logic signed [PW-1:0]    hi_win [WIN];
    logic signed [PW-1:0]    lo_win [WIN];
    logic [CW-1:0]           bar_count;
    logic [CW-1:0]           pivot_count;

    spd_pkg::pivot_t pending_pivots [$];
    row_t   plan [$];
    int     errors = 0;
    int     send_gap_pct = 15;
    int     recv_stall_pct = 72;
    bit     bar_up = 1'b0;
    bit     cfg_up = 1'b0;

    swing_pivot_detector dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .bar_valid   (bar_valid),
        .bar_ready   (bar_ready),
        .bar         (bar),
        .pivot_valid (pivot_valid),
        .pivot_ready (pivot_ready),
        .pivot       (pivot)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        pivot_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic flag(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    function automatic int clamp_arm(input logic [AW-1:0] a);
        return (a > spd_pkg::MAX_ARM) ? spd_pkg::MAX_ARM : int'(a);
    endfunction

    function automatic void restart_series();
        int k;
        for (k = 0; k < WIN; k++)
        begin
            hi_win[k] = '0;
            lo_win[k] = '0;
        end
        bar_count = '0;
        pivot_count = '0;
    endfunction

    function automatic bit judge_bar(input spd_pkg::bar_t b, output spd_pkg::pivot_t p);
        int l;
        int r;
        int span;
        int k;
        logic signed [PW-1:0] ch;
        logic signed [PW-1:0] cl;
        bit sh;
        bit sl;
        bit hit;
        l = clamp_arm(left_arm);
        r = clamp_arm(right_arm);
        span = l + r;
        for (k = WIN - 1; k > 0; k--)
        begin
            hi_win[k] = hi_win[k-1];
            lo_win[k] = lo_win[k-1];
        end
        hi_win[0] = b.bar_high;
        lo_win[0] = b.bar_low;
        p = '0;
        hit = (bar_count >= CW'(span)) && (bar_count >= first_index);
        if (hit)
        begin
            ch = hi_win[r];
            cl = lo_win[r];
            sh = 1'b1;
            sl = 1'b1;
            for (k = 0; k <= span; k++)
            begin
                if (k != r)
                begin
                    if (hi_win[k] >= ch)
                        sh = 1'b0;
                    if (lo_win[k] <= cl)
                        sl = 1'b0;
                end
            end
            if (pivot_count != spd_pkg::COUNT_MAX)
                pivot_count++;
            p.swing_high = sh;
            p.swing_low = sl;
            p.bar_index = bar_count;
            p.report_count = pivot_count;
        end
        if (bar_count != spd_pkg::COUNT_MAX)
            bar_count++;
        if (b.last_bar)
            restart_series();
        return hit;
    endfunction

    function automatic row_t pivot_row(input logic [31:0] h, input logic [31:0] l,
                                       input logic last, input logic sh, input logic sl,
                                       input logic [31:0] idx, input logic [31:0] cnt);
        row_t row;
        row.kind = ROW_BAR;
        row.item.bar_high = h;
        row.item.bar_low = l;
        row.item.last_bar = last;
        row.typed = 1'b1;
        row.has_pivot = 1'b1;
        row.want.swing_high = sh;
        row.want.swing_low = sl;
        row.want.bar_index = idx;
        row.want.report_count = cnt;
        row.reg_idx = '0;
        row.reg_val = '0;
        return row;
    endfunction

    function automatic row_t quiet_row(input logic [31:0] h, input logic [31:0] l,
                                       input logic last);
        row_t row;
        row = pivot_row(h, l, last, 1'b0, 1'b0, '0, '0);
        row.has_pivot = 1'b0;
        return row;
    endfunction

    function automatic row_t checked_row(input logic [31:0] h, input logic [31:0] l,
                                         input logic last);
        row_t row;
        row = quiet_row(h, l, last);
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic row_t cfg_row(input logic [IW-1:0] idx, input logic [DW-1:0] val);
        row_t row;
        row = quiet_row('0, '0, 1'b0);
        row.kind = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    task automatic send_bar(input spd_pkg::bar_t b);
        if (bar_up && $urandom_range(0, 99) < send_gap_pct)
        begin
            bar_valid <= 1'b0;
            bar_up = 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        bar <= b;
        bar_valid <= 1'b1;
        bar_up = 1'b1;
        do @(posedge clk); while (!bar_ready);
    endtask

    task automatic settle();
        if (bar_up)
        begin
            bar_valid <= 1'b0;
            bar_up = 1'b0;
        end
        while (pending_pivots.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        cfg_up = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            spd_pkg::REG_LEFT_BARS:   left_arm = val[AW-1:0];
            spd_pkg::REG_RIGHT_BARS:  right_arm = val[AW-1:0];
            spd_pkg::REG_START_INDEX: first_index = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        if (cfg_up)
        begin
            cfg_valid <= 1'b0;
            cfg_up = 1'b0;
        end
    endtask

    function automatic logic [AW-1:0] pick_arm();
        case ($urandom_range(0, 9))
            6: return '0;
            7: return AW'(spd_pkg::MAX_ARM);
            8: return '1;
            9: return AW'($urandom_range(0, 31));
            default: return AW'($urandom_range(0, 4));
        endcase
    endfunction

    function automatic logic [DW-1:0] pick_start();
        case ($urandom_range(0, 19))
            0: return '1;
            1: return $urandom;
            2, 3, 4, 5: return $urandom_range(1, 40);
            default: return '0;
        endcase
    endfunction

    function automatic logic [PW-1:0] pick_price(input logic [PW-1:0] anchor);
        case ($urandom_range(0, 19))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4, 5, 6, 7, 8, 9, 10: return $urandom;
            default: return anchor + $urandom_range(0, 6);
        endcase
    endfunction

    task automatic random_setup();
        logic [DW-1:0] word;
        settle();
        word = $urandom;
        word[AW-1:0] = pick_arm();
        write_reg(spd_pkg::REG_LEFT_BARS, word);
        word = $urandom;
        word[AW-1:0] = pick_arm();
        write_reg(spd_pkg::REG_RIGHT_BARS, word);
        write_reg(spd_pkg::REG_START_INDEX, pick_start());
        end_writes();
    endtask

    always @(posedge clk)
    begin : pivot_watch
        spd_pkg::pivot_t due;
        if (rst_n && pivot_valid && pivot_ready)
        begin
            if (pending_pivots.size() == 0)
            begin
                flag($sformatf("unexpected report for bar %0d", pivot.bar_index));
            end
            else
            begin
                due = pending_pivots.pop_front();
                if (pivot.swing_high !== due.swing_high)
                    flag($sformatf("bar %0d swing_high %b, want %b", due.bar_index,
                                   pivot.swing_high, due.swing_high));
                if (pivot.swing_low !== due.swing_low)
                    flag($sformatf("bar %0d swing_low %b, want %b", due.bar_index,
                                   pivot.swing_low, due.swing_low));
                if (pivot.bar_index !== due.bar_index)
                    flag($sformatf("bar_index %0d, want %0d", pivot.bar_index,
                                   due.bar_index));
                if (pivot.report_count !== due.report_count)
                    flag($sformatf("bar %0d report_count %0d, want %0d", due.bar_index,
                                   pivot.report_count, due.report_count));
            end
        end
    end

    initial
    begin
        spd_pkg::pivot_t got;
        bit          hit;
        spd_pkg::bar_t b;
        int          phase;
        int          sent;
        int          chunk;
        int unsigned series_left;
        int          start_eff;
        logic [PW-1:0] anchor;

        left_arm = spd_pkg::LEFT_BARS_RESET;
        right_arm = spd_pkg::RIGHT_BARS_RESET;
        first_index = spd_pkg::START_INDEX_RESET;
        restart_series();
        series_left = 0;

        plan.push_back(quiet_row(32'h0000_0000, 32'h0000_0000, 1'b0));
        plan.push_back(quiet_row(32'h0001_0000, 32'hFFFF_0000, 1'b0));
        plan.push_back(quiet_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        plan.push_back(quiet_row(32'h0000_0000, 32'h0000_0000, 1'b0));
        plan.push_back(pivot_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 4, 1));
        plan.push_back(checked_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        plan.push_back(checked_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        plan.push_back(cfg_row(spd_pkg::REG_LEFT_BARS, 32'hFFFF_FFE0));
        plan.push_back(cfg_row(spd_pkg::REG_RIGHT_BARS, 32'h0000_0000));
        plan.push_back(cfg_row(REG_UNUSED, 32'hFFFF_FFFF));
        plan.push_back(pivot_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 0, 1));
        plan.push_back(pivot_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, 1'b1, 1, 2));
        plan.push_back(pivot_row(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 2, 3));
        plan.push_back(cfg_row(spd_pkg::REG_LEFT_BARS, 32'd1));
        plan.push_back(cfg_row(spd_pkg::REG_RIGHT_BARS, 32'd1));
        plan.push_back(cfg_row(spd_pkg::REG_START_INDEX, 32'd3));
        plan.push_back(quiet_row(32'd5, 32'd5, 1'b0));
        plan.push_back(quiet_row(32'd5, 32'd5, 1'b0));
        plan.push_back(quiet_row(32'd3, 32'd3, 1'b0));
        plan.push_back(checked_row(32'd4, 32'd9, 1'b0));
        plan.push_back(checked_row(32'd4, 32'd9, 1'b0));
        plan.push_back(checked_row(32'hFFFF_FFF9, 32'hFFFF_FFF9, 1'b1));
        plan.push_back(cfg_row(spd_pkg::REG_START_INDEX, 32'hFFFF_FFFF));
        plan.push_back(quiet_row(32'd1, 32'd1, 1'b0));
        plan.push_back(quiet_row(32'd2, 32'd2, 1'b1));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                if (!cfg_up)
                    settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                end_writes();
                hit = judge_bar(plan[i].item, got);
                if (plan[i].typed)
                begin
                    if (plan[i].has_pivot)
                        pending_pivots.push_back(plan[i].want);
                end
                else if (hit)
                begin
                    pending_pivots.push_back(got);
                end
                send_bar(plan[i].item);
            end
        end

        for (phase = 0; phase < 3; phase++)
        begin
            send_gap_pct = (phase == 0) ? 15 : (phase == 1) ? 72 : 0;
            recv_stall_pct = (phase == 0) ? 72 : (phase == 1) ? 15 : 0;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                random_setup();
                anchor = $urandom;
                chunk = $urandom_range(30, 120);
                repeat (chunk)
                begin
                    if (series_left == 0)
                    begin
                        start_eff = (first_index <= 40) ? int'(first_index) : 0;
                        if ($urandom_range(0, 9) == 0)
                            series_left = $urandom_range(1, 6);
                        else
                            series_left = clamp_arm(left_arm) + clamp_arm(right_arm)
                                          + start_eff + $urandom_range(1, 40);
                    end
                    series_left--;
                    b.bar_high = pick_price(anchor);
                    b.bar_low = pick_price(anchor);
                    b.last_bar = (series_left == 0);
                    if (judge_bar(b, got))
                        pending_pivots.push_back(got);
                    send_bar(b);
                    sent++;
                end
            end
        end

        settle();
        if (errors == 0)
            $display("** swing_pivot_detector: PASSED **");
        else
            $display("** swing_pivot_detector: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d reports outstanding", pending_pivots.size());
        $display("** swing_pivot_detector: FAILED **");
        $finish;
    end

endmodule
